// ===== design/sfd_pkg.sv =====
// Shared types and constants for the stuffed length frame decoder.
package sfd_pkg;

    localparam int BYTE_W       = 8;
    localparam int INDEX_W      = 16;
    localparam int ESC_SHIFT    = 5;
    localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hFF;
    localparam logic [BYTE_W-1:0] ESC_XOR    = BYTE_W'(1) << ESC_SHIFT;
    localparam logic [BYTE_W-1:0] START_RST  = 8'd126;
    localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd125;

    // Configuration register indexes
    localparam logic REG_START_DELIM = 1'b0;
    localparam logic REG_ESCAPE_BYTE = 1'b1;

    // Input kind codes
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // One classified request travelling from front to back
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] raw_byte;
        logic              is_esc;
        logic              is_start;
    } sfd_entry_t;

    // One result item
    typedef struct packed {
        logic               accepted;
        logic               data_valid;
        logic [BYTE_W-1:0]  data_byte;
        logic [INDEX_W-1:0] data_index;
        logic               frame_done;
        logic               start_error;
        logic [BYTE_W-1:0]  received_checksum;
        logic [BYTE_W-1:0]  payload_sum;
    } sfd_result_t;

endpackage

// ===== design/sfd_front.sv =====
// Front end: configuration registers, input handshake and byte classification.
module sfd_front import sfd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_kind,
    input  logic [BYTE_W-1:0] s_byte,
    input  logic              q_full,
    output logic              q_push,
    output sfd_entry_t        q_entry
);

    logic [BYTE_W-1:0] start_delim_reg, start_delim_next;
    logic [BYTE_W-1:0] escape_byte_reg, escape_byte_next;

    always_comb begin
        start_delim_next = start_delim_reg;
        escape_byte_next = escape_byte_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_START_DELIM: start_delim_next = cfg_wdata;
                REG_ESCAPE_BYTE: escape_byte_next = cfg_wdata;
                default:         start_delim_next = start_delim_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_delim_reg <= START_RST;
            escape_byte_reg <= ESCAPE_RST;
        end else begin
            start_delim_reg <= start_delim_next;
            escape_byte_reg <= escape_byte_next;
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_entry.kind     = s_kind;
        q_entry.raw_byte = s_byte & BYTE_MASK;
        q_entry.is_esc   = (s_byte == escape_byte_reg);
        q_entry.is_start = (s_byte == start_delim_reg);
    end

endmodule

// ===== design/sfd_queue.sv =====
// Small request queue between front and back.
module sfd_queue import sfd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  sfd_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output sfd_entry_t pop_entry,
    output logic       empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sfd_entry_t        slot_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       count_reg,  count_next;

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + (AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/sfd_back.sv =====
// Back end: frame phase machine and registered result stage.
module sfd_back import sfd_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  sfd_entry_t  q_entry,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output sfd_result_t m_result
);

    localparam logic [3:0] PH_READY       = 4'd0;
    localparam logic [3:0] PH_LEN_HI      = 4'd1;
    localparam logic [3:0] PH_LEN_HI_ESC  = 4'd2;
    localparam logic [3:0] PH_LEN_LO      = 4'd3;
    localparam logic [3:0] PH_LEN_LO_ESC  = 4'd4;
    localparam logic [3:0] PH_PAYLOAD     = 4'd5;
    localparam logic [3:0] PH_PAYLOAD_ESC = 4'd6;
    localparam logic [3:0] PH_CHECK       = 4'd7;
    localparam logic [3:0] PH_CHECK_ESC   = 4'd8;
    localparam logic [3:0] PH_DONE        = 4'd9;
    localparam logic [3:0] PH_START_ERR   = 4'd10;

    logic [3:0]             phase_reg,   phase_next;
    logic [BYTE_W-1:0]      len_hi_reg,  len_hi_next;
    logic [LENGTH_BITS-1:0] length_reg,  length_next;
    logic [LENGTH_BITS-1:0] count_reg,   count_next;
    logic [BYTE_W-1:0]      sum_reg,     sum_next;
    logic                   out_valid_reg;
    sfd_result_t            out_reg;
    sfd_result_t            res;

    logic [BYTE_W-1:0]      unesc;
    logic [BYTE_W-1:0]      esc_sel;
    logic [2*BYTE_W-1:0]    len_full;
    logic [LENGTH_BITS-1:0] len_new;
    logic [LENGTH_BITS-1:0] count_inc;
    logic                   in_esc_phase;

    assign q_pop    = !q_empty && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    assign unesc        = q_entry.raw_byte ^ ESC_XOR;
    assign in_esc_phase = (phase_reg == PH_LEN_LO_ESC) || (phase_reg == PH_PAYLOAD_ESC)
                       || (phase_reg == PH_CHECK_ESC)  || (phase_reg == PH_LEN_HI_ESC);
    assign esc_sel      = in_esc_phase ? unesc : q_entry.raw_byte;
    assign len_full     = {len_hi_reg, esc_sel};
    assign len_new      = len_full[LENGTH_BITS-1:0];
    assign count_inc    = count_reg + LENGTH_BITS'(1);

    always_comb begin
        phase_next  = phase_reg;
        len_hi_next = len_hi_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        res         = '0;

        if (q_entry.kind == KIND_RESTART) begin
            phase_next  = PH_READY;
            len_hi_next = '0;
            length_next = '0;
            count_next  = '0;
            sum_next    = '0;
        end else begin
            res.accepted = 1'b1;
            unique case (phase_reg)
                PH_READY: begin
                    if (!q_entry.is_start) begin
                        phase_next      = PH_START_ERR;
                        res.accepted    = 1'b0;
                        res.start_error = 1'b1;
                    end else begin
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI, PH_LEN_HI_ESC: begin
                    if (phase_reg == PH_LEN_HI && q_entry.is_esc) begin
                        phase_next = PH_LEN_HI_ESC;
                    end else begin
                        len_hi_next = esc_sel;
                        phase_next  = PH_LEN_LO;
                    end
                end
                PH_LEN_LO, PH_LEN_LO_ESC: begin
                    if (phase_reg == PH_LEN_LO && q_entry.is_esc) begin
                        phase_next = PH_LEN_LO_ESC;
                    end else begin
                        length_next = len_new;
                        // zero length closes the frame with no checksum byte
                        if (len_new == '0) begin
                            phase_next     = PH_DONE;
                            res.frame_done = 1'b1;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD, PH_PAYLOAD_ESC: begin
                    if (phase_reg == PH_PAYLOAD && q_entry.is_esc) begin
                        phase_next = PH_PAYLOAD_ESC;
                    end else begin
                        res.data_valid = 1'b1;
                        res.data_byte  = esc_sel;
                        res.data_index = INDEX_W'(count_reg);
                        sum_next       = sum_reg + esc_sel;
                        count_next     = count_inc;
                        phase_next     = (count_inc == length_reg) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_CHECK, PH_CHECK_ESC: begin
                    if (phase_reg == PH_CHECK && q_entry.is_esc) begin
                        phase_next = PH_CHECK_ESC;
                    end else begin
                        phase_next            = PH_DONE;
                        res.frame_done        = 1'b1;
                        res.received_checksum = esc_sel;
                        res.payload_sum       = sum_reg;
                    end
                end
                PH_START_ERR: begin
                    res.accepted    = 1'b0;
                    res.start_error = 1'b1;
                end
                default: begin
                    res.accepted = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_READY;
            len_hi_reg    <= '0;
            length_reg    <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg  <= phase_next;
                len_hi_reg <= len_hi_next;
                length_reg <= length_next;
                count_reg  <= count_next;
                sum_reg    <= sum_next;
            end
            if (q_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= res;
        end
    end

endmodule

// ===== design/stuffed_length_frame_decoder.sv =====
// Top level of the byte-stuffed, length-prefixed frame decoder.
//
// Channel   Dir  Ports                        Contents (lowest bit first)
// input     in   s_tvalid/s_tready            s_tuser: kind; s_tdata: in_byte
// result    out  m_tvalid/m_tready            m_tuser: data_valid; m_tlast: frame_done;
//                                             m_tdata: accepted, data_byte, data_index,
//                                             start_error, received_checksum, payload_sum
// config    in   cfg_we/cfg_index/cfg_wdata   0: start_delimiter, 1: escape_byte
//
// One request per cycle sustained while the queue has room; each request yields
// exactly one result. An accepted request waits in the request queue, then the
// phase machine loads its result into the result register, raising m_tvalid.
// The front classifies bytes against the config registers and pushes into a
// QUEUE_DEPTH-entry queue; the back pops while the result register is free or
// being taken, so a stalled m_tready backs up the queue before s_tready drops.
// aresetn is synchronous and active low; no clearing pass is needed.
module stuffed_length_frame_decoder import sfd_pkg::*; #(
    parameter int LENGTH_BITS = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_wdata,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    input  logic              s_tuser,   // [0] kind

    output logic              m_tvalid,
    input  logic              m_tready,
    // [0] accepted, [8:1] data_byte, [24:9] data_index, [25] start_error,
    // [33:26] received_checksum, [41:34] payload_sum, [47:42] zero
    output logic [47:0]       m_tdata,
    output logic              m_tuser,   // [0] data_valid
    output logic              m_tlast    // frame_done
);

    sfd_entry_t  push_entry;
    sfd_entry_t  pop_entry;
    sfd_result_t result;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;

    // Front: config registers, escape/start compare, input handshake
    sfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_kind    (s_tuser),
        .s_byte    (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    // Decouple front from back so each side stalls independently
    sfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    // Back: phase machine, length/count/sum tracking, result register
    sfd_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    // Pack result fields onto the stream
    assign m_tdata = {6'b0,
                      result.payload_sum,
                      result.received_checksum,
                      result.start_error,
                      result.data_index,
                      result.data_byte,
                      result.accepted};
    assign m_tuser = result.data_valid;
    assign m_tlast = result.frame_done;

    // A queued request advances into the result register once it is free
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_empty && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("queued request not moved to result stage");

    // An accepted request not popped leaves the queue non-empty
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !q_pop) |=> !q_empty)
        else $error("accepted request lost from queue");

    // A completed frame is always reported as an accepted byte
    a_done_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[0] && !m_tuser && !m_tdata[25]))
        else $error("frame completion flagged with inconsistent status");

endmodule

// ===== tb/sv/sfd_checker.sv =====
// Checker for the frame decoder: predicts each result from the accepted requests and compares.
module sfd_checker import sfd_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [47:0]       m_tdata,
    input  logic              m_tuser,
    input  logic              m_tlast,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        DEC_IDLE, DEC_LEN_HI, DEC_LEN_HI_ESC, DEC_LEN_LO, DEC_LEN_LO_ESC,
        DEC_PAYLOAD, DEC_PAYLOAD_ESC, DEC_CHECK, DEC_CHECK_ESC, DEC_DONE, DEC_START_ERR
    } dec_phase_t;

    dec_phase_t         phase;
    logic [INDEX_W-1:0] frame_len;
    logic [INDEX_W-1:0] byte_count;
    logic [BYTE_W-1:0]  byte_sum;
    logic [BYTE_W-1:0]  start_delim;
    logic [BYTE_W-1:0]  esc_byte;
    sfd_result_t        expected_q[$];
    int                 results_seen;

    // Advance the decoder copy by one request and return the result it yields.
    function automatic sfd_result_t decode(input logic kind, input logic [BYTE_W-1:0] raw);
        sfd_result_t        r;
        logic [BYTE_W-1:0]  plain;
        logic [BYTE_W-1:0]  value;
        logic               escaped;
        logic               got_len;
        logic               got_data;
        logic               got_check;
        logic [INDEX_W-1:0] len_mask;
        r         = '0;
        plain     = raw ^ ESC_XOR;
        value     = '0;
        escaped   = (raw == esc_byte);
        got_len   = 1'b0;
        got_data  = 1'b0;
        got_check = 1'b0;
        len_mask  = INDEX_W'((64'd1 << LENGTH_BITS) - 64'd1);
        if (kind == KIND_RESTART) begin
            phase      = DEC_IDLE;
            frame_len  = '0;
            byte_count = '0;
            byte_sum   = '0;
            return r;
        end
        r.accepted = 1'b1;
        case (phase)
            DEC_IDLE: begin
                if (raw != start_delim) begin
                    phase         = DEC_START_ERR;
                    r.accepted    = 1'b0;
                    r.start_error = 1'b1;
                end else begin
                    phase = DEC_LEN_HI;
                end
            end
            DEC_LEN_HI: begin
                if (escaped) begin
                    phase = DEC_LEN_HI_ESC;
                end else begin
                    frame_len = {raw, 8'h00};
                    phase     = DEC_LEN_LO;
                end
            end
            DEC_LEN_HI_ESC: begin
                frame_len = {plain, 8'h00};
                phase     = DEC_LEN_LO;
            end
            DEC_LEN_LO: begin
                if (escaped) phase = DEC_LEN_LO_ESC;
                else begin
                    value   = raw;
                    got_len = 1'b1;
                end
            end
            DEC_LEN_LO_ESC: begin
                value   = plain;
                got_len = 1'b1;
            end
            DEC_PAYLOAD: begin
                if (escaped) phase = DEC_PAYLOAD_ESC;
                else begin
                    value    = raw;
                    got_data = 1'b1;
                end
            end
            DEC_PAYLOAD_ESC: begin
                value    = plain;
                got_data = 1'b1;
            end
            DEC_CHECK: begin
                if (escaped) phase = DEC_CHECK_ESC;
                else begin
                    value     = raw;
                    got_check = 1'b1;
                end
            end
            DEC_CHECK_ESC: begin
                value     = plain;
                got_check = 1'b1;
            end
            DEC_START_ERR: begin
                r.accepted    = 1'b0;
                r.start_error = 1'b1;
            end
            default: r.accepted = 1'b0;
        endcase
        if (got_len) begin
            frame_len = {frame_len[15:8], value} & len_mask;
            if (frame_len == '0) begin
                phase        = DEC_DONE;
                r.frame_done = 1'b1;
            end else begin
                phase = DEC_PAYLOAD;
            end
        end
        if (got_data) begin
            r.data_valid = 1'b1;
            r.data_byte  = value;
            r.data_index = byte_count;
            byte_sum     = byte_sum + value;
            byte_count   = byte_count + 1'b1;
            phase        = (byte_count == frame_len) ? DEC_CHECK : DEC_PAYLOAD;
        end
        if (got_check) begin
            phase               = DEC_DONE;
            r.frame_done        = 1'b1;
            r.received_checksum = value;
            r.payload_sum       = byte_sum;
        end
        return r;
    endfunction

    function automatic string show(input sfd_result_t r);
        return $sformatf("acc=%0b dv=%0b byte=%02h idx=%0d done=%0b err=%0b chk=%02h sum=%02h",
                         r.accepted, r.data_valid, r.data_byte, r.data_index, r.frame_done,
                         r.start_error, r.received_checksum, r.payload_sum);
    endfunction

    task automatic flag(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    always @(posedge aclk) begin
        sfd_result_t got;
        sfd_result_t want;
        string       bad;
        if (!aresetn) begin
            phase        = DEC_IDLE;
            frame_len    = '0;
            byte_count   = '0;
            byte_sum     = '0;
            start_delim  = START_RST;
            esc_byte     = ESCAPE_RST;
            fail_count   = 0;
            results_seen = 0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.accepted          = m_tdata[0];
                got.data_byte         = m_tdata[8:1];
                got.data_index        = m_tdata[24:9];
                got.start_error       = m_tdata[25];
                got.received_checksum = m_tdata[33:26];
                got.payload_sum       = m_tdata[41:34];
                got.data_valid        = m_tuser;
                got.frame_done        = m_tlast;
                if (expected_q.size() == 0) begin
                    flag($sformatf("result %0d: none expected, got %s", results_seen, show(got)));
                end else begin
                    want = expected_q.pop_front();
                    bad  = "";
                    if (got.accepted !== want.accepted)   bad = {bad, " accepted"};
                    if (got.data_valid !== want.data_valid) bad = {bad, " data_valid"};
                    if (got.data_byte !== want.data_byte)   bad = {bad, " data_byte"};
                    if (got.data_index !== want.data_index) bad = {bad, " data_index"};
                    if (got.frame_done !== want.frame_done) bad = {bad, " frame_done"};
                    if (got.start_error !== want.start_error) bad = {bad, " start_error"};
                    if (got.received_checksum !== want.received_checksum)
                        bad = {bad, " received_checksum"};
                    if (got.payload_sum !== want.payload_sum) bad = {bad, " payload_sum"};
                    if (m_tdata[47:42] !== '0) bad = {bad, " padding"};
                    if (bad != "")
                        flag($sformatf("result %0d:%s differ\n  expected %s\n  actual   %s",
                                       results_seen, bad, show(want), show(got)));
                end
                results_seen++;
            end
            // Classify against the settings in force before any write at this edge.
            if (s_tvalid && s_tready) expected_q.push_back(decode(s_tuser, s_tdata));
            if (cfg_we) begin
                case (cfg_index)
                    REG_START_DELIM: start_delim = cfg_wdata;
                    REG_ESCAPE_BYTE: esc_byte    = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the frame decoder: stimulus, receiver stalls, checker hookup and verdict.
module tb_top;
    import sfd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_index = REG_START_DELIM;
    logic [BYTE_W-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic              s_tuser   = KIND_BYTE;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [47:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    int                fail_count;
    int                pending;

    // Local copies of the register settings, used to shape well-formed frames.
    logic [BYTE_W-1:0] start_cfg = START_RST;
    logic [BYTE_W-1:0] esc_cfg   = ESCAPE_RST;
    int                item_count = 0;
    bit                burst      = 1'b0;
    bit                squeeze_req  = 1'b0;
    bit                squeeze_done = 1'b0;

    stuffed_length_frame_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    sfd_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Offer one request and hold it until the decoder takes it. Valid stays high
    // into the next request when no gap follows.
    task automatic send(input logic kind, input logic [7:0] b, input bit counted);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        if (counted) item_count++;
    endtask

    // Send one frame field, stuffing it when it collides with the escape byte
    // and now and then even when it does not.
    task automatic send_field(input logic [7:0] v);
        if (v == esc_cfg || $urandom_range(0, 99) < 15) begin
            send(KIND_BYTE, esc_cfg, 1'b1);
            send(KIND_BYTE, v ^ ESC_XOR, 1'b1);
        end else begin
            send(KIND_BYTE, v, 1'b1);
        end
    endtask

    // Send a frame of the given length, then a restart. A truncated frame stops
    // at a random field, sometimes right after an escape byte.
    task automatic send_frame(input int len, input bit truncate);
        logic [7:0]  field_q[$];
        logic [15:0] flen;
        logic [7:0]  b;
        logic [7:0]  sum;
        int          stop;
        flen = 16'(len);
        sum  = '0;
        field_q.push_back(flen[15:8]);
        field_q.push_back(flen[7:0]);
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom_range(0, 255));
            sum = sum + b;
            field_q.push_back(b);
        end
        // Checksum byte is carried, not verified: a wrong one must pass through too.
        if (len != 0) field_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : sum);
        stop = truncate ? $urandom_range(0, field_q.size() - 1) : field_q.size();
        send(KIND_BYTE, start_cfg, 1'b1);
        for (int i = 0; i < stop; i++) send_field(field_q[i]);
        if (truncate) begin
            if ($urandom_range(0, 1) == 1) send(KIND_BYTE, esc_cfg, 1'b1);
        end else begin
            // Bytes after the end of a frame are refused.
            repeat ($urandom_range(0, 2)) send(KIND_BYTE, 8'($urandom), 1'b1);
        end
        send(KIND_RESTART, 8'($urandom), 1'b1);
    endtask

    // Mostly short frames, some medium, a few long ones.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 80) return $urandom_range(1, 12);
        if (r < 97) return $urandom_range(13, 64);
        return $urandom_range(65, 160);
    endfunction

    // Drop valid, wait until every expected result has come back, then let the
    // pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [BYTE_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_framing(input logic [7:0] delim, input logic [7:0] esc);
        drain();
        write_reg(REG_START_DELIM, delim);
        write_reg(REG_ESCAPE_BYTE, esc);
        start_cfg = delim;
        esc_cfg   = esc;
    endtask

    // Random traffic until the request count reaches the target: mostly
    // well-formed frames, the rest bad starts, cut-off frames and noise.
    task automatic random_traffic(input int target);
        int         r;
        logic [7:0] b;
        while (item_count < target) begin
            burst = ($urandom_range(0, 3) == 0);
            r     = $urandom_range(0, 99);
            if (r < 70) begin
                send_frame(pick_len(), 1'b0);
            end else if (r < 80) begin
                b = 8'($urandom);
                if (b == start_cfg) b = ~b;
                send(KIND_BYTE, b, 1'b1);
                repeat ($urandom_range(0, 3)) send(KIND_BYTE, 8'($urandom), 1'b1);
                send(KIND_RESTART, 8'($urandom), 1'b1);
            end else if (r < 92) begin
                send_frame(pick_len(), 1'b1);
            end else begin
                repeat ($urandom_range(1, 5))
                    send(1'($urandom_range(0, 1)), 8'($urandom), 1'b1);
            end
        end
        burst = 1'b0;
    endtask

    // Directed opening under the reset framing (delimiter 7E, escape 7D):
    // restart from idle, empty frame and a refused byte after it, escaped low
    // length, escaped payload byte and escaped checksum, escaped high length
    // giving the largest length, then a bad start and the latched error.
    localparam logic [8:0] OPENING [25] = '{
        {KIND_RESTART, 8'hFF},
        {KIND_BYTE, 8'h7E}, {KIND_BYTE, 8'h00}, {KIND_BYTE, 8'h00},
        {KIND_BYTE, 8'hFF},
        {KIND_RESTART, 8'h00},
        {KIND_BYTE, 8'h7E}, {KIND_BYTE, 8'h00}, {KIND_BYTE, 8'h7D}, {KIND_BYTE, 8'h22},
        {KIND_BYTE, 8'h7D}, {KIND_BYTE, 8'h5D},
        {KIND_BYTE, 8'hFF},
        {KIND_BYTE, 8'h7D}, {KIND_BYTE, 8'h5E},
        {KIND_RESTART, 8'h00},
        {KIND_BYTE, 8'h7E}, {KIND_BYTE, 8'h7D}, {KIND_BYTE, 8'hDF}, {KIND_BYTE, 8'hFF},
        {KIND_BYTE, 8'h00},
        {KIND_RESTART, 8'h00},
        {KIND_BYTE, 8'h00},
        {KIND_BYTE, 8'h7E},
        {KIND_RESTART, 8'hFF}
    };

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase one: reset framing written back explicitly, directed opening, random.
        set_framing(START_RST, ESCAPE_RST);
        foreach (OPENING[i]) send(OPENING[i][8], OPENING[i][7:0], 1'b1);
        random_traffic(200);

        // Phase two: extreme framing bytes; the receiver holds off early on so
        // the queue fills and backs up into the input.
        set_framing(8'h00, 8'hFF);
        squeeze_req = 1'b1;
        random_traffic(380);

        // Phase three: the opposite extremes.
        set_framing(8'hFF, 8'h00);
        random_traffic(560);

        // Phase four: arbitrary framing bytes.
        set_framing(8'($urandom), 8'($urandom));
        random_traffic(740);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("stuffed_length_frame_decoder: match");
        end else begin
            $display("stuffed_length_frame_decoder: mismatch");
        end
        $finish;
    end

    // Receiver: ready runs of random length broken by stalls; one long hold-off
    // once requested, while the sender keeps offering.
    initial begin
        int run;
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            run = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 6) : $urandom_range(10, 60);
            repeat (run) @(posedge aclk);
            if (squeeze_req && !squeeze_done) begin
                stall        = 96;
                squeeze_done = 1'b1;
            end else begin
                stall = pick_gap();
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #800_000;
        $display("stuffed_length_frame_decoder: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
design/sfd_pkg.sv
design/sfd_front.sv
design/sfd_queue.sv
design/sfd_back.sv
design/stuffed_length_frame_decoder.sv
tb/sv/sfd_checker.sv
tb/sv/tb_top.sv
